[src/assert_macros.svh]
// Assertion helpers, clocked on clk_i and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

[src/ntc_ti_pkg.sv]
package ntc_ti_pkg;

  localparam int TABLE_DEPTH      = 64;
  localparam int IDX_W            = $clog2(TABLE_DEPTH);
  localparam int SAMPLES_AVERAGED = 4;
  localparam int AVG_SHIFT        = $clog2(SAMPLES_AVERAGED);
  localparam int ROUND_AVG        = SAMPLES_AVERAGED / 2;

  localparam int CMD_W      = 1;
  localparam int IN_IDX_W   = 6;
  localparam int SAMPLE_W   = 12;
  localparam int POINT_W    = 13;
  localparam int TEMP_W     = 19;
  localparam int ENTRY_W    = POINT_W + TEMP_W;
  localparam int CFG_W      = 7;
  localparam int TEMP_OUT_W = 16;
  localparam int SUM_W      = 14;
  localparam int CNT_W      = 2;
  localparam int CFG_RESET  = 64;

  localparam int FRAC_BITS  = 9;
  localparam int ROUND_TEMP = 512 / 2;
  localparam int RES_W      = TEMP_OUT_W + FRAC_BITS;
  localparam int DIFF_W     = POINT_W + 1;

  localparam int SLOPE_W   = 16;
  localparam int DIV_STEPS = SLOPE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  typedef enum logic {
    CMD_LOAD,
    CMD_SAMPLE
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_PAIR_RD,
    ST_PAIR0_CAP,
    ST_PAIR1_CAP,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_e;

endpackage

[src/ntc_ti_ram.sv]
module ntc_ti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/ntc_table_interpolation.sv]
// Load items and samples that do not end a group are taken without leaving ST_IDLE.
// Group-ending sample: search probes, each ST_SRCH_RD then ST_SRCH_CMP (at most
// ceil(log2(n)) probes for n entries), then ST_PAIR_RD, ST_PAIR0_CAP, ST_PAIR1_CAP,
// 16 divider steps, multiply, sum, output load. An exact hit goes straight to the
// output load, which waits while the output is stalled; input stalls meanwhile.
// Reset clears sample group and output valid, sets entry count to 64; table is unset.
`include "assert_macros.svh"

module ntc_table_interpolation (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [ntc_ti_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ntc_ti_pkg::CMD_W-1:0]         command_i,
  input  logic [ntc_ti_pkg::IN_IDX_W-1:0]      entry_index_i,
  input  logic [ntc_ti_pkg::POINT_W-1:0]       entry_point_i,
  input  logic [ntc_ti_pkg::TEMP_W-1:0]        entry_temperature_i,
  input  logic [ntc_ti_pkg::SAMPLE_W-1:0]      sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ntc_ti_pkg::TEMP_OUT_W-1:0]    temperature_o,
  output logic [ntc_ti_pkg::SAMPLE_W-1:0]      averaged_reading_o
);

  import ntc_ti_pkg::*;

  state_e                state_q, state_d;
  logic [SUM_W-1:0]      sum_q, sum_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CFG_W-1:0]      tbl_q;
  logic                  out_valid_q, out_valid_d;

  logic [SAMPLE_W-1:0]   avg_q, avg_d;
  logic [IDX_W-1:0]      lo_q, lo_d, hi_q, hi_d;
  logic [POINT_W-1:0]    x0_q, x0_d;
  logic [TEMP_W-1:0]     y0_q, y0_d;
  logic [SLOPE_W-1:0]    quo_q, quo_d;
  logic [POINT_W-1:0]    den_q, den_d;
  logic [POINT_W-1:0]    rem_q, rem_d;
  logic                  neg_q, neg_d;
  logic [DIV_CNT_W-1:0]  dcnt_q, dcnt_d;
  logic [RES_W-1:0]      prod_q, prod_d;
  logic [TEMP_OUT_W-1:0] res_q, res_d;
  logic [TEMP_OUT_W-1:0] temp_out_q;
  logic [SAMPLE_W-1:0]   avg_out_q;
  logic                  out_load;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]    ram_rdata;
  logic [POINT_W-1:0]    rd_point;
  logic [TEMP_W-1:0]     rd_temp;

  logic [IDX_W-1:0]      n_last;
  logic [IDX_W:0]        mid_sum;
  logic [IDX_W-1:0]      mid;
  logic [SUM_W-1:0]      sum_new;
  logic [SUM_W:0]        avg_round;
  logic [TEMP_W:0]       hit_sum;
  logic [IDX_W-1:0]      lo_n, hi_n;
  logic [POINT_W:0]      div_diff;
  logic [POINT_W:0]      div_shift;
  logic [SLOPE_W-1:0]    slope;
  logic [DIFF_W-1:0]     dx;
  logic [RES_W-1:0]      dx_ext, slope_ext, res_sum;

  ntc_ti_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i({entry_temperature_i, entry_point_i}),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_point  = ram_rdata[POINT_W-1:0];
  assign rd_temp   = ram_rdata[ENTRY_W-1:POINT_W];
  assign ram_waddr = IDX_W'(32'(entry_index_i) % TABLE_DEPTH);

  always_comb begin
    if (tbl_q < CFG_W'(2)) begin
      n_last = IDX_W'(1);
    end else if (32'(tbl_q) > TABLE_DEPTH) begin
      n_last = IDX_W'(TABLE_DEPTH - 1);
    end else begin
      n_last = IDX_W'(tbl_q - CFG_W'(1));
    end
  end

  assign mid_sum   = {1'b0, lo_q} + {1'b0, hi_q} + (IDX_W+1)'(1);
  assign mid       = mid_sum[IDX_W:1];
  assign sum_new   = sum_q + SUM_W'(sample_i);
  assign avg_round = {1'b0, sum_new} + (SUM_W+1)'(ROUND_AVG);
  assign hit_sum   = {1'b0, rd_temp} + (TEMP_W+1)'(ROUND_TEMP);

  // restoring divider step; a zero divisor yields all ones
  assign div_shift = {rem_q, quo_q[SLOPE_W-1]};
  assign div_diff  = div_shift - {1'b0, den_q};

  assign slope     = neg_q ? SLOPE_W'(-quo_q) : quo_q;
  assign dx        = {2'b00, avg_q} - {1'b0, x0_q};
  assign dx_ext    = {{(RES_W-DIFF_W){dx[DIFF_W-1]}}, dx};
  assign slope_ext = {{(RES_W-SLOPE_W){1'b0}}, slope};
  assign res_sum   = {{(RES_W-TEMP_W){1'b0}}, y0_q} - prod_q + RES_W'(ROUND_TEMP);

  always_comb begin
    state_d     = state_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    avg_d       = avg_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    x0_d        = x0_q;
    y0_d        = y0_q;
    quo_d       = quo_q;
    den_d       = den_q;
    rem_d       = rem_q;
    neg_d       = neg_q;
    dcnt_d      = dcnt_q;
    prod_d      = prod_q;
    res_d       = res_q;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = mid;
    lo_n        = lo_q;
    hi_n        = hi_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (command_i == CMD_LOAD) begin
            ram_we = 1'b1;
          end else if (cnt_q == CNT_W'(SAMPLES_AVERAGED - 1)) begin
            avg_d   = avg_round[AVG_SHIFT +: SAMPLE_W];
            sum_d   = '0;
            cnt_d   = '0;
            lo_d    = '0;
            hi_d    = n_last;
            state_d = ST_SRCH_RD;
          end else begin
            sum_d = sum_new;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      ST_SRCH_RD: begin
        ram_raddr = mid;
        state_d   = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        if ({1'b0, avg_q} == rd_point) begin
          res_d   = TEMP_OUT_W'(hit_sum >> FRAC_BITS);
          state_d = ST_DONE;
        end else begin
          if ({1'b0, avg_q} < rd_point) begin
            hi_n = mid - IDX_W'(1);
          end else begin
            lo_n = mid;
          end
          lo_d = lo_n;
          if (hi_n <= lo_n) begin
            hi_d    = (hi_n == n_last) ? hi_n - IDX_W'(1) : hi_n;
            state_d = ST_PAIR_RD;
          end else begin
            hi_d    = hi_n;
            state_d = ST_SRCH_RD;
          end
        end
      end
      ST_PAIR_RD: begin
        ram_raddr = hi_q;
        state_d   = ST_PAIR0_CAP;
      end
      ST_PAIR0_CAP: begin
        ram_raddr = hi_q + IDX_W'(1);
        x0_d      = rd_point;
        y0_d      = rd_temp;
        state_d   = ST_PAIR1_CAP;
      end
      ST_PAIR1_CAP: begin
        quo_d = SLOPE_W'(y0_q - rd_temp);
        if (rd_point >= x0_q) begin
          den_d = rd_point - x0_q;
          neg_d = 1'b0;
        end else begin
          den_d = x0_q - rd_point;
          neg_d = 1'b1;
        end
        rem_d   = '0;
        dcnt_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!div_diff[POINT_W] || (den_q == '0)) begin
          rem_d = div_diff[POINT_W-1:0];
          quo_d = {quo_q[SLOPE_W-2:0], 1'b1};
        end else begin
          rem_d = div_shift[POINT_W-1:0];
          quo_d = {quo_q[SLOPE_W-2:0], 1'b0};
        end
        dcnt_d = dcnt_q + DIV_CNT_W'(1);
        if (dcnt_q == DIV_LAST) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = dx_ext * slope_ext;
        state_d = ST_SUM;
      end
      ST_SUM: begin
        res_d   = res_sum[FRAC_BITS +: TEMP_OUT_W];
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      tbl_q       <= CFG_W'(CFG_RESET);
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      dcnt_q      <= dcnt_d;
      if (cfg_we_i) begin
        tbl_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    avg_q  <= avg_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    x0_q   <= x0_d;
    y0_q   <= y0_d;
    quo_q  <= quo_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    prod_q <= prod_d;
    res_q  <= res_d;
    if (out_load) begin
      temp_out_q <= res_q;
      avg_out_q  <= avg_q;
    end
  end

  assign in_stall_o         = (state_q != ST_IDLE);
  assign out_valid_o        = out_valid_q;
  assign temperature_o      = temp_out_q;
  assign averaged_reading_o = avg_out_q;

  `ASSERT_IMPLIES(a_srch_bounds, state_q == ST_SRCH_CMP, hi_q > lo_q, "search bounds collapsed")
  `ASSERT_CLK(a_div_len, (state_q == ST_DIV && dcnt_q == DIV_LAST) |=> (state_q == ST_MUL), "divider overrun")
  `ASSERT_IMPLIES(a_out_src, $rose(out_valid_o), $past(state_q == ST_DONE), "result without lookup")

endmodule

[tb/tb_ntc_table_interpolation.sv]
module tb_ntc_table_interpolation import ntc_ti_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 50;
  localparam int SEGMENT_ITEMS = 230;

  typedef struct packed {
    logic [TEMP_OUT_W-1:0] temperature;
    logic [SAMPLE_W-1:0]   reading;
  } reading_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_W-1:0]      cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [CMD_W-1:0]      command_i;
  logic [IN_IDX_W-1:0]   entry_index_i;
  logic [POINT_W-1:0]    entry_point_i;
  logic [TEMP_W-1:0]     entry_temperature_i;
  logic [SAMPLE_W-1:0]   sample_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [TEMP_OUT_W-1:0] temperature_o;
  logic [SAMPLE_W-1:0]   averaged_reading_o;

  // shadow of the block state
  logic [POINT_W-1:0] bp_point [TABLE_DEPTH];
  logic [TEMP_W-1:0]  bp_temp  [TABLE_DEPTH];
  logic [SUM_W-1:0]   acc_sum;
  int                 acc_count;
  logic [CFG_W-1:0]   entry_count;
  reading_t           pending_readings[$];

  int send_pct;
  int recv_pct;
  int mismatch_count;
  int idle_cycles;
  int group_mode;
  int group_target;

  ntc_table_interpolation uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .entry_index_i      (entry_index_i),
    .entry_point_i      (entry_point_i),
    .entry_temperature_i(entry_temperature_i),
    .sample_i           (sample_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .temperature_o      (temperature_o),
    .averaged_reading_o (averaged_reading_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int active_entries();
    int n;
    n = entry_count;
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    return n;
  endfunction

  function automatic int clamp_reading(int v);
    if (v < 0) return 0;
    if (v > 4095) return 4095;
    return v;
  endfunction

  function automatic logic [TEMP_OUT_W-1:0] interpolate_temp(logic [SAMPLE_W-1:0] avg);
    int          n, lo, hi, mid, e;
    logic [31:0] rd, x0, y0, x1, y1, num, slope, res;
    n  = active_entries();
    lo = 0;
    hi = n - 1;
    rd = 32'(avg);
    while (1) begin
      mid = (lo + hi + 1) >> 1;
      if (32'(bp_point[mid]) == rd)
        return TEMP_OUT_W'((32'(bp_temp[mid]) + 32'(ROUND_TEMP)) >> FRAC_BITS);
      if (rd < 32'(bp_point[mid])) hi = mid - 1;
      else lo = mid;
      if (hi <= lo) break;
    end
    e  = (hi == n - 1) ? hi - 1 : hi;
    x0 = 32'(bp_point[e]);
    y0 = 32'(bp_temp[e]);
    x1 = 32'(bp_point[e + 1]);
    y1 = 32'(bp_temp[e + 1]);
    num = (y0 - y1) & 32'hffff;
    if (x1 == x0) slope = 32'hffff;
    else if (x1 > x0) slope = num / (x1 - x0);
    else slope = (32'd0 - num / (x0 - x1)) & 32'hffff;
    res = (y0 - (rd - x0) * slope + 32'(ROUND_TEMP)) >> FRAC_BITS;
    return res[TEMP_OUT_W-1:0];
  endfunction

  function automatic void apply_transfer(cmd_e cmd, logic [IN_IDX_W-1:0] idx,
                                         logic [POINT_W-1:0] pt, logic [TEMP_W-1:0] tmp,
                                         logic [SAMPLE_W-1:0] smp);
    logic [SAMPLE_W-1:0] avg;
    if (cmd == CMD_LOAD) begin
      bp_point[idx] = pt;
      bp_temp[idx]  = tmp;
    end else begin
      acc_sum = acc_sum + SUM_W'(smp);
      acc_count++;
      if (acc_count == SAMPLES_AVERAGED) begin
        avg = SAMPLE_W'((32'(acc_sum) + 32'(ROUND_AVG)) >> AVG_SHIFT);
        pending_readings.push_back('{temperature: interpolate_temp(avg), reading: avg});
        acc_sum   = '0;
        acc_count = 0;
      end
    end
  endfunction

  task automatic send_item(cmd_e cmd, logic [IN_IDX_W-1:0] idx, logic [POINT_W-1:0] pt,
                           logic [TEMP_W-1:0] tmp, logic [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    command_i           <= cmd;
    entry_index_i       <= idx;
    entry_point_i       <= pt;
    entry_temperature_i <= tmp;
    sample_i            <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    apply_transfer(cmd, idx, pt, tmp, smp);
  endtask

  task automatic load_entry(int idx, int pt, int tmp);
    send_item(CMD_LOAD, IN_IDX_W'(idx), POINT_W'(pt), TEMP_W'(tmp), SAMPLE_W'($urandom));
  endtask

  task automatic send_sample(int smp);
    send_item(CMD_SAMPLE, IN_IDX_W'($urandom), POINT_W'($urandom), TEMP_W'($urandom),
              SAMPLE_W'(smp));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_entry_count(int v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= CFG_W'(v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    entry_count = CFG_W'(v);
  endtask

  // mostly ascending breakpoints, with a few flat and falling steps
  task automatic fill_table(int n);
    int x, span, r;
    span = 8000 / n + 1;
    x = $urandom_range(0, 300);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (i > 0) begin
        if (r < 8) x = x;
        else if (r < 12) x = x - $urandom_range(1, 50);
        else x = x + $urandom_range(1, span);
      end
      if (x < 0) x = 0;
      if (x > 8191) x = 8191;
      load_entry(i, x, $urandom_range(0, 19'h7ffff));
    end
  endtask

  task automatic run_random(int count);
    int n, idx, smp;
    for (int k = 0; k < count; k++) begin
      n = active_entries();
      if ($urandom_range(99) < 20) begin
        idx = $urandom_range(0, n - 1);
        if ($urandom_range(9) != 0)
          load_entry(idx, bp_point[idx], $urandom_range(0, 19'h7ffff));
        else
          load_entry($urandom_range(0, 63), $urandom_range(0, 8191),
                     $urandom_range(0, 19'h7ffff));
      end else begin
        if (acc_count == 0) begin
          group_mode   = $urandom_range(9);
          group_target = clamp_reading(bp_point[$urandom_range(0, n - 1)]);
        end
        if (group_mode < 3) smp = group_target;
        else if (group_mode < 6) smp = clamp_reading(group_target + $urandom_range(0, 8) - 4);
        else if (group_mode == 6) smp = $urandom_range(1) ? 4095 : 0;
        else smp = $urandom_range(0, 4095);
        send_sample(smp);
      end
    end
  endtask

  task automatic test_directed_lookup();
    send_pct = 7;
    recv_pct = 74;
    write_entry_count(0);
    load_entry(0, 1000, 19'h7ffff);
    load_entry(1, 3000, 0);
    repeat (4) send_sample(0);
    send_sample(1000);
    send_sample(1000);
    load_entry(63, 8191, 0);
    send_sample(1000);
    send_sample(1000);
    repeat (4) send_sample(4095);
    load_entry(1, 1000, 19'h12345);
    repeat (3) send_sample(2001);
    send_sample(2002);
    load_entry(1, 0, 19'h40000);
    repeat (4) send_sample(500);
  endtask

  task automatic test_random_traffic(int s_pct, int r_pct, int cfg_a, int cfg_b);
    int cfgs[2];
    cfgs[0] = cfg_a;
    cfgs[1] = cfg_b;
    settle();
    send_pct = s_pct;
    recv_pct = r_pct;
    foreach (cfgs[i]) begin
      write_entry_count(cfgs[i]);
      fill_table(active_entries());
      run_random(SEGMENT_ITEMS - active_entries());
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_pct);
  end

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected transfer, temperature %h reading %h", $time,
                 temperature_o, averaged_reading_o);
        mismatch_count++;
      end else begin
        want = pending_readings.pop_front();
        if (temperature_o !== want.temperature) begin
          $display("%0t: temperature exp %h got %h", $time, want.temperature, temperature_o);
          mismatch_count++;
        end
        if (averaged_reading_o !== want.reading) begin
          $display("%0t: averaged reading exp %h got %h", $time, want.reading,
                   averaged_reading_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles = 0;
    end else begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    rst_ni              <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_wdata_i         <= '0;
    in_valid_i          <= 1'b0;
    command_i           <= CMD_LOAD;
    entry_index_i       <= '0;
    entry_point_i       <= '0;
    entry_temperature_i <= '0;
    sample_i            <= '0;
    out_stall_i         <= 1'b0;
    send_pct       = 0;
    recv_pct       = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    acc_sum        = '0;
    acc_count      = 0;
    entry_count    = CFG_W'(CFG_RESET);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_lookup();
    test_random_traffic(7, 74, 127, $urandom_range(2, 63));
    test_random_traffic(74, 7, 1, 64);
    test_random_traffic(0, 0, $urandom_range(0, 127), 2);
    settle();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
